FILE: rtl/trilinear_lut_interpolator_top_defines.svh
// Assertion macros shared by the trilinear LUT interpolator RTL.
// No dependencies; pulled in by the files that carry assertions.
`ifndef TRILINEAR_LUT_INTERPOLATOR_TOP_DEFINES_SVH
`define TRILINEAR_LUT_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLI_ASSERT_IMPL(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLI_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/tli_pkg.sv
// Shared widths, command codes and request types for the trilinear LUT interpolator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tli_pkg;

  localparam int COORD_W   = 24;
  localparam int VAL_W     = 16;
  localparam int NUM_VALS  = 4;
  localparam int ENTRY_W   = 64;
  localparam int TADDR_W   = 12;
  localparam int IDX_W     = 4;
  localparam int PTS_W     = 5;
  localparam int CMD_W     = 2;
  localparam int SEL_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_BANKS = 8;
  localparam int BANK_AW   = 9;

  localparam logic [CMD_W-1:0] CMD_AXIS_WR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TABLE_WR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;

  localparam logic [SEL_W-1:0] AXIS_AEROSOL = 2'd0;
  localparam logic [SEL_W-1:0] AXIS_WATER   = 2'd1;
  localparam logic [SEL_W-1:0] AXIS_WAVE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_AEROSOL_PTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATER_PTS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_PTS    = 2'd2;

  // Axis point write request handed to one locator.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] val;
  } axis_wr_t;

endpackage
`default_nettype wire

FILE: rtl/tli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/tli_wdiv.sv
// Pipelined restoring divider forming the interpolation weight, two quotient bits per stage.
// Depends on tli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tli_wdiv #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic [tli_pkg::COORD_W-1:0]   rem_in,
  input  wire logic [tli_pkg::COORD_W-1:0]   div_in,
  input  wire logic                          zero_in,
  input  wire logic                          sat_in,
  input  wire logic [tli_pkg::IDX_W-1:0]     idx_in,
  output logic      [FRAC_BITS:0]            w_out,
  output logic      [tli_pkg::IDX_W-1:0]     idx_out
);

  localparam int DS = (FRAC_BITS + 1) / 2;
  localparam int CW = tli_pkg::COORD_W;

  logic [CW-1:0]             rem_src [DS];
  logic [CW-1:0]             div_src [DS];
  logic [FRAC_BITS-1:0]      quo_src [DS];
  logic                      zero_src [DS];
  logic                      sat_src [DS];
  logic [tli_pkg::IDX_W-1:0] idx_src [DS];

  logic [CW-1:0]             rem_nxt [DS];
  logic [FRAC_BITS-1:0]      quo_nxt [DS];

  logic [CW-1:0]             rem_r [DS];
  logic [CW-1:0]             div_r [DS];
  logic [FRAC_BITS-1:0]      quo_r [DS];
  logic                      zero_r [DS];
  logic                      sat_r [DS];
  logic [tli_pkg::IDX_W-1:0] idx_r [DS];

  for (genvar s = 0; s < DS; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_src[s]  = rem_in;
      assign div_src[s]  = div_in;
      assign quo_src[s]  = '0;
      assign zero_src[s] = zero_in;
      assign sat_src[s]  = sat_in;
      assign idx_src[s]  = idx_in;
    end else begin : g_next
      assign rem_src[s]  = rem_r[s-1];
      assign div_src[s]  = div_r[s-1];
      assign quo_src[s]  = quo_r[s-1];
      assign zero_src[s] = zero_r[s-1];
      assign sat_src[s]  = sat_r[s-1];
      assign idx_src[s]  = idx_r[s-1];
    end

    // Shift in one quotient bit per step; skip steps past the fraction width.
    always_comb begin : p_steps
      logic [CW:0]          r2;
      logic [CW-1:0]        rem_v;
      logic [FRAC_BITS-1:0] quo_v;
      rem_v = rem_src[s];
      quo_v = quo_src[s];
      for (int b = 0; b < 2; b++) begin
        if ((2 * s + b) < FRAC_BITS) begin
          r2 = {rem_v, 1'b0};
          if (r2 >= {1'b0, div_src[s]}) begin
            r2    = r2 - {1'b0, div_src[s]};
            quo_v = {quo_v[FRAC_BITS-2:0], 1'b1};
          end else begin
            quo_v = {quo_v[FRAC_BITS-2:0], 1'b0};
          end
          rem_v = r2[CW-1:0];
        end
      end
      rem_nxt[s] = rem_v;
      quo_nxt[s] = quo_v;
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt[s];
      quo_r[s]  <= quo_nxt[s];
      div_r[s]  <= div_src[s];
      zero_r[s] <= zero_src[s];
      sat_r[s]  <= sat_src[s];
      idx_r[s]  <= idx_src[s];
    end
  end

  always_comb begin
    if (zero_r[DS-1]) begin
      w_out = '0;
    end else if (sat_r[DS-1]) begin
      w_out = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      w_out = {1'b0, quo_r[DS-1]};
    end
  end

  assign idx_out = idx_r[DS-1];

endmodule
`default_nettype wire

FILE: rtl/tli_locate.sv
// One grid axis: point storage, clamp, bracket search and weight division pipeline.
// Depends on tli_pkg, tli_ram and tli_wdiv.
`timescale 1ns / 1ps
`default_nettype none
module tli_locate #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tli_pkg::axis_wr_t             wr,
  input  wire logic [tli_pkg::COORD_W-1:0]   q,
  input  wire logic [tli_pkg::PTS_W-1:0]     points,
  output logic      [tli_pkg::IDX_W-1:0]     lo,
  output logic      [FRAC_BITS:0]            w
);

  localparam int PT_LIMIT = (MAX_POINTS < 16) ? MAX_POINTS : 16;
  localparam int AW       = $clog2(PT_LIMIT);
  localparam int CW       = tli_pkg::COORD_W;
  localparam int IW       = tli_pkg::IDX_W;
  localparam int PW       = tli_pkg::PTS_W;

  logic [CW-1:0]    front_r [PT_LIMIT];
  logic [PW-1:0]    n_eff;
  logic [PW-1:0]    nm1;
  logic [PW-1:0]    nm2;
  logic [CW-1:0]    top_v;
  logic [CW-1:0]    q_lo;
  logic [CW-1:0]    qc;
  logic [(1<<IW)-1:0] flags;
  logic             wr_ok;

  logic [CW-1:0]      qc1_r;
  logic [(1<<IW)-1:0] flags1_r;
  logic               low1_r;
  logic               high1_r;
  logic               wr1_we_r;
  logic [IW-1:0]      wr1_idx_r;
  logic [CW-1:0]      wr1_val_r;

  logic [PW-1:0] lo_v;
  logic [PW-1:0] hi_v;
  logic [PW-1:0] mid;
  logic [IW-1:0] lo_sel;
  logic [IW-1:0] hi_sel;

  logic [IW-1:0] lo2_r;
  logic [CW-1:0] qc2_r;
  logic [CW-1:0] lv;
  logic [CW-1:0] hv;

  logic signed [CW:0] d;
  logic signed [CW:0] off;
  logic               zero;
  logic               sat;

  always_comb begin
    if (points < 5'd2) begin
      n_eff = 5'd2;
    end else if (points > PW'(PT_LIMIT)) begin
      n_eff = PW'(PT_LIMIT);
    end else begin
      n_eff = points;
    end
  end

  assign nm1   = n_eff - 5'd1;
  assign nm2   = n_eff - 5'd2;
  assign top_v = front_r[nm1[AW-1:0]];
  assign wr_ok = wr.we && ({1'b0, wr.idx} < PW'(PT_LIMIT));

  // Clamp the lower end first, then the upper end.
  assign q_lo = (q < front_r[0]) ? front_r[0] : q;
  assign qc   = (q_lo > top_v) ? top_v : q_lo;

  for (genvar i = 0; i < (1 << IW); i++) begin : g_flag
    if (i < PT_LIMIT) begin : g_used
      assign flags[i] = (front_r[i] <= qc);
    end else begin : g_unused
      assign flags[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      front_r[wr.idx[AW-1:0]] <= wr.val;
    end
    qc1_r     <= qc;
    flags1_r  <= flags;
    low1_r    <= (qc <= front_r[0]);
    high1_r   <= (qc >= top_v);
    wr1_idx_r <= wr.idx;
    wr1_val_r <= wr.val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr1_we_r <= 1'b0;
    end else begin
      wr1_we_r <= wr_ok;
    end
  end

  // Binary search over the registered compare flags.
  always_comb begin
    lo_v = '0;
    hi_v = nm1;
    mid  = '0;
    for (int k = 0; k < IW; k++) begin
      if ((hi_v - lo_v) > 5'd1) begin
        mid = (lo_v + hi_v) >> 1;
        if (flags1_r[mid[IW-1:0]]) begin
          lo_v = mid;
        end else begin
          hi_v = mid;
        end
      end
    end
    if (low1_r) begin
      lo_sel = '0;
    end else if (high1_r) begin
      lo_sel = nm2[IW-1:0];
    end else begin
      lo_sel = lo_v[IW-1:0];
    end
  end

  assign hi_sel = lo_sel + 4'd1;

  // Two more copies of the axis, updated in pipeline order for the interval reads.
  tli_ram #(.WIDTH(CW), .DEPTH(PT_LIMIT)) u_lo_ram (
    .clk   (clk),
    .we    (wr1_we_r),
    .waddr (wr1_idx_r[AW-1:0]),
    .wdata (wr1_val_r),
    .raddr (lo_sel[AW-1:0]),
    .rdata (lv)
  );

  tli_ram #(.WIDTH(CW), .DEPTH(PT_LIMIT)) u_hi_ram (
    .clk   (clk),
    .we    (wr1_we_r),
    .waddr (wr1_idx_r[AW-1:0]),
    .wdata (wr1_val_r),
    .raddr (hi_sel[AW-1:0]),
    .rdata (hv)
  );

  always_ff @(posedge clk) begin
    lo2_r <= lo_sel;
    qc2_r <= qc1_r;
  end

  assign d    = $signed({1'b0, hv}) - $signed({1'b0, lv});
  assign off  = $signed({1'b0, qc2_r}) - $signed({1'b0, lv});
  assign zero = !((d > 25'sd0) && (off > 25'sd0));
  assign sat  = (off >= d);

  tli_wdiv #(.FRAC_BITS(FRAC_BITS)) u_wdiv (
    .clk     (clk),
    .rem_in  (off[CW-1:0]),
    .div_in  (d[CW-1:0]),
    .zero_in (zero),
    .sat_in  (sat),
    .idx_in  (lo2_r),
    .w_out   (w),
    .idx_out (lo)
  );

endmodule
`default_nettype wire

FILE: rtl/tli_blend.sv
// Three-level blend of eight corners for four values: wavelength, water, then aerosol.
// Depends on tli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tli_blend #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                                clk,
  input  wire logic [tli_pkg::NUM_BANKS-1:0][tli_pkg::ENTRY_W-1:0] corners,
  input  wire logic [FRAC_BITS:0]                                  ww,
  input  wire logic [FRAC_BITS:0]                                  wh,
  input  wire logic [FRAC_BITS:0]                                  wa,
  output logic      [tli_pkg::NUM_VALS-1:0][tli_pkg::VAL_W-1:0]    res
);

  localparam int VW = tli_pkg::VAL_W;
  localparam int NV = tli_pkg::NUM_VALS;

  // a + w*(b - a), truncated; equals ((1-w)a + wb) >> FRAC_BITS.
  function automatic logic [VW-1:0] mix(input logic [VW-1:0] a, input logic [VW-1:0] b,
                                        input logic [FRAC_BITS:0] wt);
    logic signed [VW:0]             diff;
    logic signed [FRAC_BITS+1:0]    ws;
    logic signed [FRAC_BITS+VW+2:0] prod;
    logic signed [FRAC_BITS+VW+2:0] acc;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    ws   = $signed({1'b0, wt});
    prod = diff * ws;
    acc  = $signed({3'b000, a, {FRAC_BITS{1'b0}}}) + prod;
    return acc[FRAC_BITS+VW-1:FRAC_BITS];
  endfunction

  logic [VW-1:0]    m1_r [NV][2][2];
  logic [VW-1:0]    m2_r [NV][2];
  logic [VW-1:0]    res_r [NV];
  logic [FRAC_BITS:0] wh1_r;
  logic [FRAC_BITS:0] wa1_r;
  logic [FRAC_BITS:0] wa2_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < NV; k++) begin
      for (int da = 0; da < 2; da++) begin
        for (int dh = 0; dh < 2; dh++) begin
          m1_r[k][da][dh] <= mix(corners[da*4 + dh*2][k*VW +: VW],
                                 corners[da*4 + dh*2 + 1][k*VW +: VW], ww);
        end
        m2_r[k][da] <= mix(m1_r[k][da][0], m1_r[k][da][1], wh1_r);
      end
      res_r[k] <= mix(m2_r[k][0], m2_r[k][1], wa2_r);
    end
    wh1_r <= wh;
    wa1_r <= wa;
    wa2_r <= wa1_r;
  end

  for (genvar k = 0; k < NV; k++) begin : g_res
    assign res[k] = res_r[k];
  end

endmodule
`default_nettype wire

FILE: rtl/trilinear_lut_interpolator_top.sv
// A query result strobes out on out_valid after the request is taken; axis and table
// writes give no result.
// Throughput: one request per cycle while busy is low; the 2-bit-per-stage weight divider and the
// eight parity banks of the table keep every stage busy with a new request.
// Reset (rst_n low, synchronous) clears the point counts to 2 and all valid bits; busy
// falls in the cycle after release. Grid and table contents are not cleared.
// Depends on tli_pkg, tli_locate, tli_blend, tli_ram and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "trilinear_lut_interpolator_top_defines.svh"
module trilinear_lut_interpolator_top #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [tli_pkg::CMD_W-1:0]           in_cmd,
  input  wire logic [tli_pkg::SEL_W-1:0]           in_axis_select,
  input  wire logic [tli_pkg::IDX_W-1:0]           in_axis_point_index,
  input  wire logic [tli_pkg::COORD_W-1:0]         in_axis_point_value,
  input  wire logic [tli_pkg::TADDR_W-1:0]         in_entry_address,
  input  wire logic [tli_pkg::VAL_W-1:0]           in_path_reflectance_in,
  input  wire logic [tli_pkg::VAL_W-1:0]           in_down_transmit_in,
  input  wire logic [tli_pkg::VAL_W-1:0]           in_up_transmit_in,
  input  wire logic [tli_pkg::VAL_W-1:0]           in_sphere_albedo_in,
  input  wire logic [tli_pkg::COORD_W-1:0]         in_aerosol_query,
  input  wire logic [tli_pkg::COORD_W-1:0]         in_water_query,
  input  wire logic [tli_pkg::COORD_W-1:0]         in_wavelength_query,
  output logic                                     out_valid,
  output logic      [tli_pkg::VAL_W-1:0]           out_path_reflectance,
  output logic      [tli_pkg::VAL_W-1:0]           out_down_transmit,
  output logic      [tli_pkg::VAL_W-1:0]           out_up_transmit,
  output logic      [tli_pkg::VAL_W-1:0]           out_sphere_albedo,
  input  wire logic                                cfg_we,
  input  wire logic [tli_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tli_pkg::PTS_W-1:0]           cfg_wdata
);

  localparam int DS      = (FRAC_BITS + 1) / 2;
  localparam int LOC_LAT = 2 + DS;     // request taken -> bracket index and weight
  localparam int LAT     = LOC_LAT + 4; // plus bank read and three blend levels
  localparam int NB      = tli_pkg::NUM_BANKS;
  localparam int EW      = tli_pkg::ENTRY_W;
  localparam int IW      = tli_pkg::IDX_W;
  localparam logic [FRAC_BITS:0] W_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic busy_r;
  logic accept;
  logic acc_q;
  logic acc_t;

  logic [tli_pkg::PTS_W-1:0] aerosol_pts_r;
  logic [tli_pkg::PTS_W-1:0] water_pts_r;
  logic [tli_pkg::PTS_W-1:0] wave_pts_r;

  tli_pkg::axis_wr_t wr_a;
  tli_pkg::axis_wr_t wr_h;
  tli_pkg::axis_wr_t wr_w;

  logic [IW-1:0]      ia;
  logic [IW-1:0]      ih;
  logic [IW-1:0]      iw;
  logic [FRAC_BITS:0] wa;
  logic [FRAC_BITS:0] wh;
  logic [FRAC_BITS:0] ww;

  logic [LAT-1:0]               qv_r;
  logic [LOC_LAT-1:0]           tw_v_r;
  logic [tli_pkg::TADDR_W-1:0]  tw_addr_r [LOC_LAT];
  logic [EW-1:0]                tw_data_r [LOC_LAT];

  logic [tli_pkg::TADDR_W-1:0]  wr_addr;
  logic [2:0]                   wr_bank;
  logic [EW-1:0]                bank_rd [NB];
  logic [NB-1:0][EW-1:0]        corners;

  logic               par_a_r;
  logic               par_h_r;
  logic               par_w_r;
  logic [FRAC_BITS:0] wa_r;
  logic [FRAC_BITS:0] wh_r;
  logic [FRAC_BITS:0] ww_r;

  logic [tli_pkg::NUM_VALS-1:0][tli_pkg::VAL_W-1:0] res;

  // Request handshake: nothing stalls the pipe, so busy only covers reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r && rst_n;
  assign acc_q  = accept && (in_cmd == tli_pkg::CMD_QUERY);
  assign acc_t  = accept && (in_cmd == tli_pkg::CMD_TABLE_WR);

  // Point counts; the user must write them only while the pipe is empty, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aerosol_pts_r <= 5'd2;
      water_pts_r   <= 5'd2;
      wave_pts_r    <= 5'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        tli_pkg::CFG_AEROSOL_PTS: aerosol_pts_r <= cfg_wdata;
        tli_pkg::CFG_WATER_PTS:   water_pts_r   <= cfg_wdata;
        tli_pkg::CFG_WAVE_PTS:    wave_pts_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Route axis point writes; an unused selector goes nowhere.
  always_comb begin
    wr_a.we  = accept && (in_cmd == tli_pkg::CMD_AXIS_WR) &&
               (in_axis_select == tli_pkg::AXIS_AEROSOL);
    wr_a.idx = in_axis_point_index;
    wr_a.val = in_axis_point_value;
    wr_h.we  = accept && (in_cmd == tli_pkg::CMD_AXIS_WR) &&
               (in_axis_select == tli_pkg::AXIS_WATER);
    wr_h.idx = in_axis_point_index;
    wr_h.val = in_axis_point_value;
    wr_w.we  = accept && (in_cmd == tli_pkg::CMD_AXIS_WR) &&
               (in_axis_select == tli_pkg::AXIS_WAVE);
    wr_w.idx = in_axis_point_index;
    wr_w.val = in_axis_point_value;
  end

  tli_locate #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_loc_aerosol (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr_a),
    .q      (in_aerosol_query),
    .points (aerosol_pts_r),
    .lo     (ia),
    .w      (wa)
  );

  tli_locate #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_loc_water (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr_h),
    .q      (in_water_query),
    .points (water_pts_r),
    .lo     (ih),
    .w      (wh)
  );

  tli_locate #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_loc_wave (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr_w),
    .q      (in_wavelength_query),
    .points (wave_pts_r),
    .lo     (iw),
    .w      (ww)
  );

  // Valid bits for queries, and table writes delayed to the stage where queries read
  // the table, so reads and writes land in request order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r   <= '0;
      tw_v_r <= '0;
    end else begin
      qv_r   <= {qv_r[LAT-2:0], acc_q};
      tw_v_r <= {tw_v_r[LOC_LAT-2:0], acc_t};
    end
  end

  always_ff @(posedge clk) begin
    tw_addr_r[0] <= in_entry_address;
    tw_data_r[0] <= {in_sphere_albedo_in, in_up_transmit_in,
                     in_down_transmit_in, in_path_reflectance_in};
    for (int k = 1; k < LOC_LAT; k++) begin
      tw_addr_r[k] <= tw_addr_r[k-1];
      tw_data_r[k] <= tw_data_r[k-1];
    end
  end

  assign wr_addr = tw_addr_r[LOC_LAT-1];
  assign wr_bank = {wr_addr[8], wr_addr[4], wr_addr[0]};

  // Banks split by index parity on each axis: the eight corners always hit eight
  // different banks. Each bank sees index i or i+1, whichever has its parity.
  for (genvar b = 0; b < NB; b++) begin : g_bank
    localparam logic PA = ((b / 4) % 2) == 1;
    localparam logic PH = ((b / 2) % 2) == 1;
    localparam logic PW = (b % 2) == 1;
    logic [IW-1:0]               a_b;
    logic [IW-1:0]               h_b;
    logic [IW-1:0]               w_b;
    logic [tli_pkg::BANK_AW-1:0] raddr;

    assign a_b   = ia + {3'b000, PA ^ ia[0]};
    assign h_b   = ih + {3'b000, PH ^ ih[0]};
    assign w_b   = iw + {3'b000, PW ^ iw[0]};
    assign raddr = {a_b[3:1], h_b[3:1], w_b[3:1]};

    tli_ram #(.WIDTH(EW), .DEPTH(1 << tli_pkg::BANK_AW)) u_bank (
      .clk   (clk),
      .we    (tw_v_r[LOC_LAT-1] && (wr_bank == 3'(b))),
      .waddr ({wr_addr[11:9], wr_addr[7:5], wr_addr[3:1]}),
      .wdata (tw_data_r[LOC_LAT-1]),
      .raddr (raddr),
      .rdata (bank_rd[b])
    );
  end

  // Hold parities and weights for the bank read cycle.
  always_ff @(posedge clk) begin
    par_a_r <= ia[0];
    par_h_r <= ih[0];
    par_w_r <= iw[0];
    wa_r    <= wa;
    wh_r    <= wh;
    ww_r    <= ww;
  end

  // Put bank data back into corner order {aerosol, water, wavelength} offset.
  for (genvar c = 0; c < NB; c++) begin : g_corner
    localparam logic DA = ((c / 4) % 2) == 1;
    localparam logic DH = ((c / 2) % 2) == 1;
    localparam logic DW = (c % 2) == 1;
    assign corners[c] = bank_rd[{par_a_r ^ DA, par_h_r ^ DH, par_w_r ^ DW}];
  end

  tli_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk     (clk),
    .corners (corners),
    .ww      (ww_r),
    .wh      (wh_r),
    .wa      (wa_r),
    .res     (res)
  );

  assign out_valid            = qv_r[LAT-1];
  assign out_path_reflectance = res[0];
  assign out_down_transmit    = res[1];
  assign out_up_transmit      = res[2];
  assign out_sphere_albedo    = res[3];

  `TLI_ASSERT_IMPL(a_out_from_query, clk, rst_n, out_valid, $past(acc_q, LAT))
  `TLI_ASSERT_IMPL(a_weight_range, clk, rst_n, qv_r[LOC_LAT-1], (wa <= W_ONE) && (wh <= W_ONE) && (ww <= W_ONE))
  `TLI_ASSERT_IMPL(a_table_port_excl, clk, rst_n, qv_r[LOC_LAT-1], !tw_v_r[LOC_LAT-1])
  `TLI_ASSERT_NEXT(a_busy_release, clk, rst_n, busy, !busy)

endmodule
`default_nettype wire
